### design/ufs_pkg.sv
package ufs_pkg;

  localparam int PHI_W           = 18;
  localparam int VEL_W           = 16;
  localparam int VSUM_W          = VEL_W + 1;
  localparam int FLUX_W          = 32;
  localparam int ORDER_W         = 2;
  localparam int ORDERS          = 4;
  localparam int TAPS            = 7;
  localparam int COEF_W          = 18;
  localparam int PROD_W          = PHI_W + COEF_W;
  localparam int SUM_W           = PROD_W;
  localparam int MUL_W           = SUM_W + VSUM_W;
  localparam int ROUND_SH        = 18;
  localparam int WINDOW_LEN_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;
  localparam int REG_IDX_W       = APB_ADDR_W - 2;

  typedef logic signed [PHI_W-1:0]  phi_t;
  typedef logic signed [VEL_W-1:0]  vel_t;
  typedef logic signed [VSUM_W-1:0] vsum_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [ORDER_W-1:0]       order_t;

  localparam logic [REG_IDX_W-1:0] REG_SCHEME_ORDER = REG_IDX_W'(0);
  localparam order_t               ORDER_RESET      = ORDER_W'(1);

  localparam coef_t COEF_TAB [ORDERS][TAPS] = '{
    '{coef_t'(65536), coef_t'(0), coef_t'(0), coef_t'(0), coef_t'(0), coef_t'(0),
      coef_t'(0)},
    '{-coef_t'(14020), coef_t'(60809), coef_t'(18748), coef_t'(0), coef_t'(0),
      coef_t'(0), coef_t'(0)},
    '{coef_t'(3634), -coef_t'(19998), coef_t'(60035), coef_t'(23693), -coef_t'(1827),
      coef_t'(0), coef_t'(0)},
    '{-coef_t'(1037), coef_t'(7315), -coef_t'(24295), coef_t'(61156), coef_t'(24857),
      -coef_t'(2515), coef_t'(55)}
  };

  typedef struct packed {
    phi_t [TAPS-1:0] taps;
    vsum_t           vsum;
    order_t          order;
    logic            flux_valid;
  } job_t;

endpackage

### design/ufs_stream_if.sv
interface ufs_in_if;
  import ufs_pkg::*;

  logic valid;
  logic ready;
  phi_t phi_sample;
  vel_t vel_sample;
  logic line_start;

  modport source (output valid, output phi_sample, output vel_sample, output line_start,
                  input ready);
  modport sink (input valid, input phi_sample, input vel_sample, input line_start,
                output ready);
endinterface

interface ufs_out_if;
  import ufs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [FLUX_W-1:0] flux;
  logic                     flux_valid;

  modport source (output valid, output flux, output flux_valid, input ready);
  modport sink (input valid, input flux, input flux_valid, output ready);
endinterface

### design/ufs_front.sv
module ufs_front #(
  parameter int WINDOW_LEN = ufs_pkg::WINDOW_LEN_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ufs_pkg::phi_t   phi_i,
  input  ufs_pkg::vel_t   vel_i,
  input  logic            line_start_i,
  input  ufs_pkg::order_t order_i,
  input  logic            q_full_i,
  output logic            push_o,
  output ufs_pkg::job_t   job_o
);
  import ufs_pkg::*;

  localparam int HALF  = WINDOW_LEN / 2;
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  phi_t             phi_q [WINDOW_LEN];
  phi_t             phi_d [WINDOW_LEN];
  vel_t             vel_q [WINDOW_LEN];
  vel_t             vel_d [WINDOW_LEN];
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  phi_t             tap_p [ORDERS][TAPS];
  phi_t             tap_n [ORDERS][TAPS];
  vsum_t            vsum;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    phi_d[0] = phi_i;
    vel_d[0] = vel_i;
    for (int i = 1; i < WINDOW_LEN; i++) begin
      phi_d[i] = phi_q[i-1];
      vel_d[i] = vel_q[i-1];
    end
    if (line_start_i) begin
      cnt_d = CNT_W'(1);
    end else if (cnt_q < CNT_W'(WINDOW_LEN)) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        phi_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else if (push_o) begin
      cnt_q <= cnt_d;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        phi_q[i] <= phi_d[i];
        vel_q[i] <= vel_d[i];
      end
    end
  end

  for (genvar gk = 0; gk < ORDERS; gk++) begin : g_order
    for (genvar gi = 0; gi < TAPS; gi++) begin : g_tap
      localparam int AGE_P = HALF + gk - gi;
      localparam int AGE_N = HALF - 1 - gk + gi;
      if (gi < 2 * gk + 1 && AGE_P >= 0 && AGE_P < WINDOW_LEN) begin : g_p
        assign tap_p[gk][gi] = phi_d[AGE_P];
      end else begin : g_pz
        assign tap_p[gk][gi] = '0;
      end
      if (gi < 2 * gk + 1 && AGE_N >= 0 && AGE_N < WINDOW_LEN) begin : g_n
        assign tap_n[gk][gi] = phi_d[AGE_N];
      end else begin : g_nz
        assign tap_n[gk][gi] = '0;
      end
    end
  end

  assign vsum = {vel_d[HALF][VEL_W-1], vel_d[HALF]} + {vel_d[HALF-1][VEL_W-1], vel_d[HALF-1]};

  always_comb begin
    job_o.vsum       = vsum;
    job_o.order      = order_i;
    job_o.flux_valid = (cnt_d == CNT_W'(WINDOW_LEN));
    for (int i = 0; i < TAPS; i++) begin
      job_o.taps[i] = vsum[VSUM_W-1] ? tap_n[order_i][i] : tap_p[order_i][i];
    end
  end

endmodule

### design/ufs_queue.sv
module ufs_queue #(
  parameter int DEPTH = ufs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ufs_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ufs_pkg::job_t data_o
);
  import ufs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

### design/ufs_back.sv
module ufs_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  input  ufs_pkg::job_t                    job_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [ufs_pkg::FLUX_W-1:0] flux_o,
  output logic                             flux_valid_o
);
  import ufs_pkg::*;

  localparam int SH_W = MUL_W + 1 - ROUND_SH;
  localparam logic signed [SH_W-1:0] SAT_HI = {{(SH_W - FLUX_W + 1){1'b0}},
                                               {(FLUX_W - 1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_LO = {{(SH_W - FLUX_W + 1){1'b1}},
                                               {(FLUX_W - 1){1'b0}}};
  localparam logic signed [MUL_W:0]  RND    = (MUL_W + 1)'(1) <<< (ROUND_SH - 1);

  logic                     adv;
  logic signed [PROD_W-1:0] prod_d [TAPS];
  logic signed [PROD_W-1:0] p1_q [TAPS];
  logic signed [SUM_W-1:0]  s2_q [4];
  logic signed [SUM_W-1:0]  s3_q;
  logic signed [MUL_W-1:0]  m4_q;
  vsum_t                    vs1_q, vs2_q, vs3_q;
  logic                     v1_q, v2_q, v3_q, v4_q;
  logic                     fv1_q, fv2_q, fv3_q, fv4_q;
  logic signed [MUL_W:0]    rnd;
  logic signed [SH_W-1:0]   sh;
  logic signed [FLUX_W-1:0] flux_d;
  logic                     out_vld_q;
  logic signed [FLUX_W-1:0] flux_q;
  logic                     fv_q;

  assign adv   = !out_vld_q || out_ready_i;
  assign pop_o = adv && job_valid_i;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      prod_d[i] = $signed(COEF_TAB[job_i.order][i]) * $signed(job_i.taps[i]);
    end
  end

  always_comb begin
    rnd = {m4_q[MUL_W-1], m4_q} + RND;
    sh  = SH_W'(rnd >>> ROUND_SH);
    if (!fv4_q) begin
      flux_d = '0;
    end else if (sh > SAT_HI) begin
      flux_d = SAT_HI[FLUX_W-1:0];
    end else if (sh < SAT_LO) begin
      flux_d = SAT_LO[FLUX_W-1:0];
    end else begin
      flux_d = sh[FLUX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < TAPS; i++) begin
        p1_q[i] <= prod_d[i];
      end
      vs1_q   <= job_i.vsum;
      fv1_q   <= job_i.flux_valid;
      s2_q[0] <= p1_q[0] + p1_q[1];
      s2_q[1] <= p1_q[2] + p1_q[3];
      s2_q[2] <= p1_q[4] + p1_q[5];
      s2_q[3] <= p1_q[6];
      vs2_q   <= vs1_q;
      fv2_q   <= fv1_q;
      s3_q    <= (s2_q[0] + s2_q[1]) + (s2_q[2] + s2_q[3]);
      vs3_q   <= vs2_q;
      fv3_q   <= fv2_q;
      m4_q    <= s3_q * vs3_q;
      fv4_q   <= fv3_q;
      flux_q  <= flux_d;
      fv_q    <= fv4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= pop_o;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      out_vld_q <= v4_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign flux_o       = flux_q;
  assign flux_valid_o = fv_q;

endmodule

### design/upwind_face_flux_stencil.sv
// Upwind-biased advective flux over one streamed line of lattice samples.
// in_i carries one site per word: phi_sample (Q3.14), vel_sample (Q0.15)
// and line_start, which restarts the sample count of a new line.
// out_o returns one word per input word, in order: flux (Q4.27, saturated)
// for the face between the samples four and three places back, and
// flux_valid once the window holds WINDOW_LEN samples of the current
// line; flux reads zero while flux_valid is low.
// scheme_order sits at APB byte address 0 and picks the 1-, 3-, 5- or
// 7-point stencil; write it only while the block is idle.
// Path: a word accepted on in_i passes one queue slot, three product/sum
// stages and one multiply stage, then the rounding and saturation into
// the output register, before it shows on out_o. Throughput: one word
// per cycle unless out_o stalls, set by the seven-multiplier stage.
// Reset clears the window, the sample count and the pipeline, and sets
// scheme_order to 1, the 3-point stencil.
// When out_o stalls the back pipeline holds; the four-entry queue between
// the window and the pipeline absorbs words until it fills, then in_i.ready
// drops.
module upwind_face_flux_stencil #(
  parameter int WINDOW_LEN  = ufs_pkg::WINDOW_LEN_DEF,
  parameter int QUEUE_DEPTH = ufs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ufs_in_if.sink                            in_i,
  ufs_out_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ufs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ufs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ufs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ufs_pkg::*;

  order_t               order_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  job_t                 job_in;
  job_t                 job_out;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_SCHEME_ORDER) ? APB_DATA_W'(order_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
    end else if (cfg_wr && reg_idx == REG_SCHEME_ORDER) begin
      order_q <= pwdata[ORDER_W-1:0];
    end
  end

  ufs_front #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .phi_i       (in_i.phi_sample),
    .vel_i       (in_i.vel_sample),
    .line_start_i(in_i.line_start),
    .order_i     (order_q),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .job_o       (job_in)
  );

  ufs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (job_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (job_out)
  );

  ufs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .pop_o       (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .flux_o      (out_o.flux),
    .flux_valid_o(out_o.flux_valid)
  );

`ifndef SYNTH
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.flux_valid |-> out_o.flux == '0)
    else $error("flux nonzero while flux_valid is low");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && reg_idx == REG_SCHEME_ORDER |=> order_q == $past(pwdata[ORDER_W-1:0]))
    else $error("scheme_order write lost");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !q_pop)
    else $error("queue popped while output stalled");
`endif

endmodule
